// ----- design/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
// Holds the request codes, status codes, controller states and the cell link types.
// No dependencies.
package skt_pkg;

	localparam int KeyW = 32;
	localparam int EntryCountW = 5;
	localparam int StatusW = 2;
	localparam int CapacityDef = 16;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_DELETE = 1'b1
	} skt_action_t;

	typedef enum logic [StatusW-1:0] {
		STATUS_DONE = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL = 2'd2
	} skt_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY
	} skt_state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic del_en;
		logic signed [KeyW-1:0] key;
	} skt_cmd_t;

	// What a cell shows to its neighbors.
	typedef struct packed {
		logic signed [KeyW-1:0] key;
		logic valid;
		logic lt;
		logic le;
	} skt_link_t;

endpackage

// ----- design/skt_cell.sv -----
// One slot of the sorted key table: a stored key, its valid bit and its compare flags.
// Depends on skt_pkg for the command and link types.
module skt_cell (
	input logic clk,
	input logic arst_n,
	input skt_pkg::skt_cmd_t cmd,
	input skt_pkg::skt_link_t prev,
	input logic signed [skt_pkg::KeyW-1:0] next_key,
	input logic next_valid,
	output skt_pkg::skt_link_t link,
	output logic hit
);

	logic signed [skt_pkg::KeyW-1:0] key_q;
	logic valid_q;
	logic lt_q;
	logic le_q;
	logic eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q <= 1'b0;
			le_q <= 1'b0;
			eq_q <= 1'b0;
		end else begin
			if (cmd.cmp_en) begin
				lt_q <= valid_q && (key_q < cmd.key);
				le_q <= valid_q && (key_q <= cmd.key);
				eq_q <= valid_q && (key_q == cmd.key);
			end
			// The table is a filled prefix, so an insert grows it by one slot.
			if (cmd.ins_en) begin
				valid_q <= valid_q | prev.valid;
			end else if (cmd.del_en && !lt_q) begin
				valid_q <= next_valid;
			end
		end
	end

	// On insert, the first slot holding a larger key (or empty) takes the new key and
	// every slot after it takes its left neighbor. On delete, slots from the match on
	// take their right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !le_q) begin
			key_q <= prev.le ? cmd.key : prev.key;
		end else if (cmd.del_en && !lt_q) begin
			key_q <= next_key;
		end
	end

	assign link = '{key: key_q, valid: valid_q, lt: lt_q, le: le_q};

	// Only the first slot that is not below the key can be the earliest equal key.
	assign hit = eq_q & prev.lt;

endmodule

// ----- design/sorted_key_table.sv -----
// Sorted key table: a row of cells holding signed keys in ascending order.
// Depends on skt_pkg and skt_cell.
//
// Each request is first registered; then every cell compares its key with the
// request key; then the row shifts by a slot and the result is written to the output
// register. A new request is taken in the cycle after its predecessor's result is
// written, even if that result has not been transferred yet; the shift step waits
// only while the output register is still full. Inserts go after all equal keys,
// deletes remove the earliest equal key. Reset empties the table at once.
module sorted_key_table #(
	parameter int CAPACITY = skt_pkg::CapacityDef
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata,   // [31:0] key
	input logic [0:0] s_tuser,    // [0] action
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,   // [4:0] entry_count, [7:5] zero
	output logic [1:0] m_tuser    // [1:0] status
);

	localparam int CntW = $clog2(CAPACITY + 1);

	skt_pkg::skt_state_t state_q;
	skt_pkg::skt_state_t state_nxt;
	skt_pkg::skt_action_t req_action_q;
	logic signed [skt_pkg::KeyW-1:0] req_key_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_nxt;
	logic m_tvalid_q;
	skt_pkg::skt_status_t status_q;
	skt_pkg::skt_status_t status_nxt;
	logic [skt_pkg::EntryCountW-1:0] entry_count_q;

	logic cmp_en;
	logic apply_go;
	logic full;
	logic found;
	skt_pkg::skt_cmd_t cmd;
	skt_pkg::skt_link_t links [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;
	logic [CAPACITY-1:0] valid_vec;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			skt_pkg::ST_IDLE: if (s_tvalid) state_nxt = skt_pkg::ST_CMP;
			skt_pkg::ST_CMP: state_nxt = skt_pkg::ST_APPLY;
			skt_pkg::ST_APPLY: if (!m_tvalid_q || m_tready) state_nxt = skt_pkg::ST_IDLE;
			default: state_nxt = skt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == skt_pkg::ST_IDLE);
		cmp_en = (state_q == skt_pkg::ST_CMP);
		apply_go = (state_q == skt_pkg::ST_APPLY) && (!m_tvalid_q || m_tready);
	end

	assign full = (count_q == CntW'(CAPACITY));
	assign found = |hit_vec;

	always_comb begin
		cmd.cmp_en = cmp_en;
		cmd.ins_en = apply_go && (req_action_q == skt_pkg::ACT_INSERT) && !full;
		cmd.del_en = apply_go && (req_action_q == skt_pkg::ACT_DELETE) && found;
		cmd.key = req_key_q;
	end

	always_comb begin
		count_nxt = count_q;
		status_nxt = skt_pkg::STATUS_DONE;
		if (req_action_q == skt_pkg::ACT_INSERT) begin
			if (full) status_nxt = skt_pkg::STATUS_FULL;
			else count_nxt = count_q + CntW'(1);
		end else begin
			if (!found) status_nxt = skt_pkg::STATUS_NOT_FOUND;
			else count_nxt = count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::ST_IDLE;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (apply_go) begin
				count_q <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_action_q <= skt_pkg::skt_action_t'(s_tuser[0]);
			req_key_q <= s_tdata;
		end
		if (apply_go) begin
			status_q <= status_nxt;
			entry_count_q <= skt_pkg::EntryCountW'(count_nxt);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skt_pkg::skt_link_t prev_link;
		logic signed [skt_pkg::KeyW-1:0] nkey;
		logic nvalid;

		if (i == 0) begin : g_first
			assign prev_link = '{key: '0, valid: 1'b1, lt: 1'b1, le: 1'b1};
		end else begin : g_mid
			assign prev_link = links[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign nkey = '0;
			assign nvalid = 1'b0;
		end else begin : g_inner
			assign nkey = links[i+1].key;
			assign nvalid = links[i+1].valid;
		end

		skt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.prev(prev_link),
			.next_key(nkey),
			.next_valid(nvalid),
			.link(links[i]),
			.hit(hit_vec[i])
		);

		assign valid_vec[i] = links[i].valid;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = status_q;
	assign m_tdata = {3'b000, entry_count_q};

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("stored count exceeds capacity");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell claims the delete match");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("valid cells disagree with the stored count");

	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> valid_vec[0])
		else $error("first cell empty in a nonempty table");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q == skt_pkg::STATUS_FULL) |-> full)
		else $error("full status reported while the table has room");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for sorted_key_table: drives insert and delete requests, predicts each result.
// Depends on skt_pkg and the sorted_key_table RTL.
module tb;

	localparam int Capacity = skt_pkg::CapacityDef;
	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 80;
	localparam int DrainCycles = 10;
	localparam int RandomItems = 1800;
	localparam int IdlePct = 37;

	typedef logic signed [skt_pkg::KeyW-1:0] key_t;

	typedef struct {
		skt_pkg::skt_status_t status;
		logic [skt_pkg::EntryCountW-1:0] entry_count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;  // [31:0] key
	logic [0:0] s_tuser = '0;   // [0] action
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;        // [4:0] entry_count, [7:5] zero
	logic [1:0] m_tuser;        // [1:0] status

	key_t stored_keys[$];
	table_result_t pending_results[$];
	key_t common_keys[6] = '{key_t'(32'h8000_0000), key_t'(32'h7fff_ffff), -1, 0, 1, 2};
	int error_count = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	sorted_key_table #(.CAPACITY(Capacity)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Applies one request to the shadow table and returns the status and count it yields.
	function automatic table_result_t apply_request(skt_pkg::skt_action_t act, key_t k);
		table_result_t r;
		int pos;
		pos = 0;
		if (act == skt_pkg::ACT_INSERT) begin
			if (stored_keys.size() >= Capacity) begin
				r.status = skt_pkg::STATUS_FULL;
			end else begin
				while (pos < stored_keys.size() && stored_keys[pos] <= k) pos++;
				stored_keys.insert(pos, k);
				r.status = skt_pkg::STATUS_DONE;
			end
		end else begin
			while (pos < stored_keys.size() && stored_keys[pos] < k) pos++;
			if (pos < stored_keys.size() && stored_keys[pos] == k) begin
				stored_keys.delete(pos);
				r.status = skt_pkg::STATUS_DONE;
			end else begin
				r.status = skt_pkg::STATUS_NOT_FOUND;
			end
		end
		r.entry_count = skt_pkg::EntryCountW'(stored_keys.size());
		return r;
	endfunction

	task automatic send_request(input skt_pkg::skt_action_t act, input key_t k);
		if (idle_on && $urandom_range(99) < IdlePct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= k;
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_request(act, k));
	endtask

	function automatic key_t random_key();
		if ($urandom_range(1))
			return common_keys[$urandom_range(5)];
		return key_t'($urandom);
	endfunction

	function automatic key_t stored_or_random_key();
		if (stored_keys.size() > 0 && $urandom_range(3) != 0)
			return stored_keys[$urandom_range(stored_keys.size() - 1)];
		return random_key();
	endfunction

	// The receiver stalls at random, or holds off for a long stretch when asked.
	always begin
		@(posedge clk);
		if (hold_req) begin
			m_tready <= 1'b0;
			repeat (HoldCycles) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < IdlePct);
		end
	end

	always @(posedge clk) begin
		table_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result expected none actual status %0d count %0d", $time,
					m_tuser, m_tdata[skt_pkg::EntryCountW-1:0]);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status) begin
					error_count++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
				end
				if (m_tdata[skt_pkg::EntryCountW-1:0] != want.entry_count) begin
					error_count++;
					$display("%0t: entry_count expected %0d actual %0d", $time,
						want.entry_count, m_tdata[skt_pkg::EntryCountW-1:0]);
				end
			end
		end
	end

	// Empty table, extreme keys, equal keys and absent keys.
	task automatic test_extremes();
		send_request(skt_pkg::ACT_DELETE, 0);
		send_request(skt_pkg::ACT_INSERT, key_t'(32'h7fff_ffff));
		send_request(skt_pkg::ACT_INSERT, key_t'(32'h8000_0000));
		send_request(skt_pkg::ACT_INSERT, 0);
		send_request(skt_pkg::ACT_INSERT, -1);
		send_request(skt_pkg::ACT_INSERT, 0);
		send_request(skt_pkg::ACT_INSERT, 1);
		send_request(skt_pkg::ACT_INSERT, key_t'(32'h5555_aaaa));
		send_request(skt_pkg::ACT_DELETE, 5);
		send_request(skt_pkg::ACT_DELETE, 0);
		send_request(skt_pkg::ACT_DELETE, key_t'(32'h8000_0000));
		send_request(skt_pkg::ACT_DELETE, key_t'(32'h7fff_ffff));
		send_request(skt_pkg::ACT_DELETE, 0);
		send_request(skt_pkg::ACT_DELETE, 0);
		send_request(skt_pkg::ACT_DELETE, -1);
		send_request(skt_pkg::ACT_DELETE, 1);
		send_request(skt_pkg::ACT_DELETE, key_t'(32'h5555_aaaa));
		send_request(skt_pkg::ACT_DELETE, -1);
	endtask

	// Fill the table, overflow it, then drain it in random order.
	task automatic test_full_table();
		while (stored_keys.size() < Capacity) send_request(skt_pkg::ACT_INSERT, random_key());
		repeat (3) send_request(skt_pkg::ACT_INSERT, random_key());
		send_request(skt_pkg::ACT_DELETE, 3);
		while (stored_keys.size() > 0)
			send_request(skt_pkg::ACT_DELETE,
				stored_keys[$urandom_range(stored_keys.size() - 1)]);
	endtask

	// The receiver holds off while requests keep coming, so the input stalls.
	task automatic test_back_pressure();
		hold_req = 1'b1;
		repeat (12)
			send_request(($urandom_range(99) < 70) ? skt_pkg::ACT_INSERT : skt_pkg::ACT_DELETE,
				stored_or_random_key());
	endtask

	task automatic test_random_mix();
		int insert_pct;
		skt_pkg::skt_action_t act;
		insert_pct = 65;
		for (int n = 0; n < RandomItems; n++) begin
			// Alternate between filling and draining phases.
			if (n % 100 == 0)
				insert_pct = ((n / 100) % 2 == 0) ? 65 : 35;
			idle_on = !(n >= 700 && n < 1000);
			act = ($urandom_range(99) < insert_pct) ? skt_pkg::ACT_INSERT : skt_pkg::ACT_DELETE;
			if (act == skt_pkg::ACT_DELETE)
				send_request(act, stored_or_random_key());
			else
				send_request(act, random_key());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_full_table();
		test_back_pressure();
		test_random_mix();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
design/skt_pkg.sv
design/skt_cell.sv
design/sorted_key_table.sv
sim/tb.sv
